/* design/efns_pkg.sv */
// Shared constants, types and helpers for the earliest-free-node scheduler.
package efns_pkg;

  // Sizing
  localparam int MAX_NODES = 32;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int CFG_W     = 6;
  localparam int DUR_W     = 32;
  localparam int TIME_W    = 48;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Node store read request
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
  } rd_req_t;

  // Node store write request
  typedef struct packed {
    logic              en;
    logic [NODE_W-1:0] addr;
    logic [TIME_W-1:0] data;
  } wr_req_t;

  // Node store read response: end time and the node's used flag
  typedef struct packed {
    logic [TIME_W-1:0] data;
    logic              used;
  } rd_rsp_t;

  // Register write value, limited to the node count
  function automatic logic [CFG_W-1:0] cfg_limit(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (int'(v) > MAX_NODES) begin
      r = CFG_W'(MAX_NODES);
    end
    return r;
  endfunction

  // Nodes taking part in a scan; zero means all of them
  function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = CNT_W'(v);
    if (v == '0 || int'(v) > MAX_NODES) begin
      r = CNT_W'(MAX_NODES);
    end
    return r;
  endfunction

endpackage

/* design/efns_if.sv */
// Channel interfaces: job input, schedule result and node-count write.
interface efns_in_if;
  logic                         valid;
  logic                         ready;
  logic [efns_pkg::DUR_W-1:0]   duration;

  modport source (output valid, output duration, input ready);
  modport sink   (input valid, input duration, output ready);
endinterface

interface efns_out_if;
  logic                         valid;
  logic                         ready;
  logic [efns_pkg::NODE_W-1:0]  node;
  logic [efns_pkg::TIME_W-1:0]  start_time;
  logic [efns_pkg::TIME_W-1:0]  end_time;
  logic [efns_pkg::TIME_W-1:0]  latency;

  modport source (output valid, output node, output start_time, output end_time,
                  output latency, input ready);
  modport sink   (input valid, input node, input start_time, input end_time,
                  input latency, output ready);
endinterface

interface efns_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [efns_pkg::CFG_W-1:0]   num_nodes;

  modport source (output valid, output num_nodes, input ready);
  modport sink   (input valid, input num_nodes, output ready);
endinterface

/* design/efns_node_store.sv */
// Per-node state: end-time memory with registered read, used flags in flops.
module efns_node_store (
  input  logic              clk,
  input  logic              rst_n,
  input  efns_pkg::rd_req_t rd_req,
  output efns_pkg::rd_rsp_t rd_rsp,
  input  efns_pkg::wr_req_t wr_req
);

  logic [efns_pkg::TIME_W-1:0]    end_mem [efns_pkg::MAX_NODES];
  logic [efns_pkg::MAX_NODES-1:0] used_r;
  logic [efns_pkg::TIME_W-1:0]    rd_data_r;
  logic                           rd_used_r;

  // End-time memory, one write and one read port
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      end_mem[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      rd_data_r <= end_mem[rd_req.addr];
    end
  end

  // Used flags; reset marks every node as never used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      rd_used_r <= 1'b0;
    end else begin
      if (wr_req.en) begin
        used_r[wr_req.addr] <= 1'b1;
      end
      if (rd_req.en) begin
        rd_used_r <= used_r[rd_req.addr];
      end
    end
  end

  assign rd_rsp.data = rd_data_r;
  assign rd_rsp.used = rd_used_r;

endmodule

/* design/earliest_free_node_scheduler.sv */
// Top level of the earliest-free-node greedy list scheduler.
// Each job transaction is placed on the lowest-numbered node that has never been
// used, starting at time 0, or else on the node whose last job ends earliest
// (lowest index on a tie), starting at that end time. End times saturate at
// 2^48-1 and the latency output is the largest end time so far. The scan over
// the active node count reads one node end time per cycle from the single read
// port of the node memory, and stops early at the first unused node. A finished
// result sits in an output register, so the next job is taken while it waits.
// The node count register may be written only while no job is in flight; zero
// selects all nodes.
module earliest_free_node_scheduler (
  input  logic           clk,
  input  logic           rst_n,
  efns_in_if.sink        in_ch,
  efns_out_if.source     out_ch,
  efns_cfg_if.sink       cfg_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_CALC = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [efns_pkg::CFG_W-1:0]     num_nodes_r;
  logic [efns_pkg::DUR_W-1:0]     dur_r, dur_nxt;
  logic [efns_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [efns_pkg::CNT_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                           pend_r, pend_nxt;
  logic [efns_pkg::NODE_W-1:0]    pend_idx_r, pend_idx_nxt;
  logic                           pend_last_r, pend_last_nxt;
  logic [efns_pkg::NODE_W-1:0]    best_idx_r, best_idx_nxt;
  logic [efns_pkg::TIME_W-1:0]    best_end_r, best_end_nxt;
  logic                           have_r, have_nxt;
  logic                           fresh_r, fresh_nxt;
  logic [efns_pkg::TIME_W-1:0]    start_r, start_nxt;
  logic [efns_pkg::TIME_W-1:0]    end_r, end_nxt;
  logic [efns_pkg::TIME_W-1:0]    lat_r, lat_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [efns_pkg::NODE_W-1:0]    out_node_r, out_node_nxt;
  logic [efns_pkg::TIME_W-1:0]    out_start_r, out_start_nxt;
  logic [efns_pkg::TIME_W-1:0]    out_end_r, out_end_nxt;
  logic [efns_pkg::TIME_W-1:0]    out_lat_r, out_lat_nxt;

  logic                           in_fire;
  logic                           issue;
  logic                           out_free;
  logic [efns_pkg::TIME_W-1:0]    calc_start;
  logic [efns_pkg::TIME_W:0]      calc_sum;
  efns_pkg::rd_req_t              rd_req;
  efns_pkg::rd_rsp_t              rd_rsp;
  efns_pkg::wr_req_t              wr_req;

  efns_node_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_req (rd_req),
    .rd_rsp (rd_rsp),
    .wr_req (wr_req)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // Read issue during the scan: one node per cycle
  assign issue       = (state_r == S_SCAN) && (rd_idx_r < cnt_r);
  assign rd_req.en   = issue;
  assign rd_req.addr = rd_idx_r[efns_pkg::NODE_W-1:0];

  // Start and unsaturated end sum, with carry bit, of the chosen node
  assign calc_start = fresh_r ? '0 : best_end_r;
  assign calc_sum   = {1'b0, calc_start} + (efns_pkg::TIME_W + 1)'(dur_r);

  // Write-back of the new end time as the result leaves
  assign wr_req.en   = (state_r == S_DONE) && out_free;
  assign wr_req.addr = best_idx_r;
  assign wr_req.data = end_r;

  // Sequencer and datapath
  always_comb begin
    state_nxt     = state_r;
    dur_nxt       = dur_r;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = rd_idx_r[efns_pkg::NODE_W-1:0];
    pend_last_nxt = (rd_idx_r == cnt_r - efns_pkg::CNT_W'(1));
    best_idx_nxt  = best_idx_r;
    best_end_nxt  = best_end_r;
    have_nxt      = have_r;
    fresh_nxt     = fresh_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    lat_nxt       = lat_r;
    out_valid_nxt = out_valid_r;
    out_node_nxt  = out_node_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    out_lat_nxt   = out_lat_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          dur_nxt    = in_ch.duration;
          cnt_nxt    = efns_pkg::active_count(num_nodes_r);
          rd_idx_nxt = '0;
          have_nxt   = 1'b0;
          fresh_nxt  = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          rd_idx_nxt = rd_idx_r + efns_pkg::CNT_W'(1);
        end
        // Compare stage on the data read last cycle
        if (pend_r) begin
          if (!rd_rsp.used) begin
            best_idx_nxt = pend_idx_r;
            fresh_nxt    = 1'b1;
            state_nxt    = S_CALC;
          end else begin
            if (!have_r || rd_rsp.data < best_end_r) begin
              best_idx_nxt = pend_idx_r;
              best_end_nxt = rd_rsp.data;
              have_nxt     = 1'b1;
            end
            if (pend_last_r) begin
              state_nxt = S_CALC;
            end
          end
        end
      end
      S_CALC: begin
        start_nxt = calc_start;
        end_nxt   = calc_sum[efns_pkg::TIME_W] ? efns_pkg::TIME_MAX
                                               : calc_sum[efns_pkg::TIME_W-1:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          if (end_r > lat_r) begin
            lat_nxt     = end_r;
            out_lat_nxt = end_r;
          end else begin
            out_lat_nxt = lat_r;
          end
          out_valid_nxt = 1'b1;
          out_node_nxt  = best_idx_r;
          out_start_nxt = start_r;
          out_end_nxt   = end_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      num_nodes_r <= efns_pkg::cfg_limit(efns_pkg::CFG_W'(32));
      lat_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lat_r       <= lat_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        num_nodes_r <= efns_pkg::cfg_limit(cfg_ch.num_nodes);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    dur_r       <= dur_nxt;
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_last_r <= pend_last_nxt;
    best_idx_r  <= best_idx_nxt;
    best_end_r  <= best_end_nxt;
    have_r      <= have_nxt;
    fresh_r     <= fresh_nxt;
    start_r     <= start_nxt;
    end_r       <= end_nxt;
    out_node_r  <= out_node_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    out_lat_r   <= out_lat_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.node       = out_node_r;
  assign out_ch.start_time = out_start_r;
  assign out_ch.end_time   = out_end_r;
  assign out_ch.latency    = out_lat_r;

endmodule
